// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define OB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ob_match check failed");

// checked on every clock edge, reset included
`define OB_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("ob_match check failed during reset");

`endif

// ===== rtl/ob_match_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ob_match_pkg;

  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 144;

  typedef enum logic [1:0] {
    KIND_FILL     = 2'd0,
    KIND_RESTED   = 2'd1,
    KIND_FILLED   = 2'd2,
    KIND_REJECTED = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_EREAD,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic        reject;
    logic [31:0] user;
    logic [31:0] quantity;
    logic [5:0]  price;
    logic [3:0]  ticker;
    logic        is_buy;
  } order_t;

  typedef struct packed {
    logic        last;
    kind_e       kind;
    logic [31:0] rest_quantity;
    logic [31:0] fill_quantity;
    logic [5:0]  out_price;
    logic [3:0]  out_ticker;
    logic        buy_side_incoming;
    logic [31:0] incoming_user;
    logic [31:0] resting_user;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ob_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ob_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ob_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ob_front #(
  parameter int unsigned NUM_TICKERS  = 16,
  parameter int unsigned PRICE_LEVELS = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 busy_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [ob_match_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                                      ord_valid_o,
  output ob_match_pkg::order_t                      ord_o,
  input  wire logic                                 ord_pop_i
);

  ob_match_pkg::order_t mem_q [2];
  ob_match_pkg::order_t req;
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  always_comb begin
    req.is_buy   = s_axis_tdata[0];
    req.ticker   = s_axis_tdata[4:1];
    req.price    = s_axis_tdata[10:5];
    req.quantity = s_axis_tdata[42:11];
    req.user     = s_axis_tdata[74:43];
    req.reject   = (32'(req.ticker) >= 32'(NUM_TICKERS)) ||
                   (32'(req.price) >= 32'(PRICE_LEVELS));
  end

  assign s_axis_tready = !busy_i && (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign ord_valid_o   = (cnt_q != 2'd0);
  assign ord_o         = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !ord_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && ord_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= !wp_q;
      end
      if (ord_pop_i) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= req;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ob_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ob_back #(
  parameter int unsigned NUM_TICKERS  = 16,
  parameter int unsigned PRICE_LEVELS = 64,
  parameter int unsigned QUEUE_DEPTH  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  output logic                       busy_o,
  input  wire logic                  ord_valid_i,
  input  wire ob_match_pkg::order_t  ord_i,
  output logic                       ord_pop_o,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output ob_match_pkg::res_t         res_o
);

  localparam int unsigned NUM_LEVELS  = NUM_TICKERS * PRICE_LEVELS;
  localparam int unsigned LW          = $clog2(NUM_LEVELS);
  localparam int unsigned NUM_ENTRIES = NUM_LEVELS * QUEUE_DEPTH;
  localparam int unsigned EW          = $clog2(NUM_ENTRIES);
  localparam int unsigned HW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW          = $clog2(2 * QUEUE_DEPTH + 1);
  localparam int unsigned LDW         = 1 + HW + CW;

  ob_match_pkg::state_e state_q, state_d;
  ob_match_pkg::order_t ord_q, ord_d;
  ob_match_pkg::res_t   out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic [LW-1:0]        clr_q, clr_d;
  logic [LW-1:0]        lvl_q, lvl_d;
  logic [EW-1:0]        base_q, base_d;
  logic                 bid_q, bid_d;
  logic [HW-1:0]        head_q, head_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [31:0]          qty_q, qty_d;
  logic                 matched_q, matched_d;
  logic                 rej_q, rej_d;

  logic                 lv_we, lv_re;
  logic [LW-1:0]        lv_waddr, lv_raddr;
  logic [LDW-1:0]       lv_wdata, lv_rdata;
  logic                 en_we, en_re;
  logic [EW-1:0]        en_waddr, en_raddr;
  logic [63:0]          en_wdata, en_rdata;

  logic                 out_free;
  logic                 rd_bid;
  logic [HW-1:0]        rd_head, head_inc;
  logic [CW-1:0]        rd_cnt;
  logic [EW-1:0]        base_w;
  logic [SW-1:0]        tail_sum;
  logic [HW-1:0]        tail;
  logic [31:0]          rq, ruser;

  ob_ram #(.WIDTH(LDW), .DEPTH(NUM_LEVELS)) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (lv_we),
    .waddr_i(lv_waddr),
    .wdata_i(lv_wdata),
    .re_i   (lv_re),
    .raddr_i(lv_raddr),
    .rdata_o(lv_rdata)
  );

  ob_ram #(.WIDTH(64), .DEPTH(NUM_ENTRIES)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (en_we),
    .waddr_i(en_waddr),
    .wdata_i(en_wdata),
    .re_i   (en_re),
    .raddr_i(en_raddr),
    .rdata_o(en_rdata)
  );

  assign out_free    = !out_valid_q || res_ready_i;
  assign rd_bid      = lv_rdata[LDW-1];
  assign rd_head     = lv_rdata[CW+HW-1:CW];
  assign rd_cnt      = lv_rdata[CW-1:0];
  assign base_w      = EW'(EW'(lvl_q) * EW'(QUEUE_DEPTH));
  assign head_inc    = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : HW'(head_q + 1'b1);
  assign tail_sum    = SW'(head_q) + SW'(cnt_q);
  assign tail        = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : HW'(tail_sum);
  assign rq          = en_rdata[31:0];
  assign ruser       = en_rdata[63:32];
  assign busy_o      = (state_q == ob_match_pkg::ST_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    ord_d       = ord_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_ready_i;
    clr_d       = clr_q;
    lvl_d       = lvl_q;
    base_d      = base_q;
    bid_d       = bid_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    qty_d       = qty_q;
    matched_d   = matched_q;
    rej_d       = rej_q;
    ord_pop_o   = 1'b0;
    lv_we       = 1'b0;
    lv_waddr    = lvl_q;
    lv_wdata    = {bid_q, head_q, cnt_q};
    lv_re       = 1'b0;
    lv_raddr    = LW'(LW'(ord_i.ticker) * LW'(PRICE_LEVELS) + LW'(ord_i.price));
    en_we       = 1'b0;
    en_waddr    = base_q + EW'(head_q);
    en_wdata    = {ruser, rq - qty_q};
    en_re       = 1'b0;
    en_raddr    = base_w + EW'(rd_head);

    // output register holds its request until it is taken
    if (out_free) begin
      out_d.incoming_user     = ord_q.user;
      out_d.buy_side_incoming = ord_q.is_buy;
      out_d.out_ticker        = ord_q.ticker;
      out_d.out_price         = ord_q.price;
      out_d.resting_user      = '0;
      out_d.fill_quantity     = '0;
      out_d.rest_quantity     = '0;
      out_d.last              = 1'b1;
      out_d.kind              = ob_match_pkg::KIND_REJECTED;
    end

    unique case (state_q)
      ob_match_pkg::ST_CLEAR: begin
        lv_we    = 1'b1;
        lv_waddr = clr_q;
        lv_wdata = '0;
        clr_d    = LW'(clr_q + 1'b1);
        if (clr_q == LW'(NUM_LEVELS - 1)) begin
          state_d = ob_match_pkg::ST_IDLE;
        end
      end
      ob_match_pkg::ST_IDLE: begin
        if (ord_valid_i) begin
          ord_pop_o = 1'b1;
          ord_d     = ord_i;
          qty_d     = ord_i.quantity;
          rej_d     = ord_i.reject;
          matched_d = 1'b0;
          lvl_d     = lv_raddr;
          lv_re     = !ord_i.reject;
          state_d   = ord_i.reject ? ob_match_pkg::ST_FINAL : ob_match_pkg::ST_LOOK;
        end
      end
      ob_match_pkg::ST_LOOK: begin
        bid_d  = rd_bid;
        head_d = rd_head;
        cnt_d  = rd_cnt;
        base_d = base_w;
        matched_d = (rd_cnt != '0) && (rd_bid != ord_q.is_buy);
        if (matched_d && (qty_q != '0)) begin
          en_re   = 1'b1;
          state_d = ob_match_pkg::ST_EREAD;
        end else begin
          state_d = ob_match_pkg::ST_FINAL;
        end
      end
      ob_match_pkg::ST_EREAD: begin
        en_raddr = base_q + EW'(head_inc);
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.kind         = ob_match_pkg::KIND_FILL;
          out_d.last         = 1'b0;
          out_d.resting_user = ruser;
          if (qty_q >= rq) begin
            out_d.fill_quantity = rq;
            qty_d  = qty_q - rq;
            head_d = head_inc;
            cnt_d  = cnt_q - 1'b1;
            if ((cnt_d != '0) && (qty_d != '0)) begin
              en_re = 1'b1;
            end else begin
              state_d = ob_match_pkg::ST_FINAL;
            end
          end else begin
            out_d.fill_quantity = qty_q;
            en_we   = 1'b1;
            qty_d   = '0;
            state_d = ob_match_pkg::ST_FINAL;
          end
        end
      end
      ob_match_pkg::ST_FINAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ob_match_pkg::ST_IDLE;
          if (rej_q) begin
            out_d.kind = ob_match_pkg::KIND_REJECTED;
          end else if (matched_q && ((qty_q == '0) || (cnt_q != '0))) begin
            lv_we      = 1'b1;
            out_d.kind = ob_match_pkg::KIND_FILLED;
          end else if (cnt_q >= CW'(QUEUE_DEPTH)) begin
            out_d.kind = ob_match_pkg::KIND_REJECTED;
          end else begin
            en_we    = 1'b1;
            en_waddr = base_q + EW'(tail);
            en_wdata = {ord_q.user, qty_q};
            lv_we    = 1'b1;
            lv_wdata = {(cnt_q == '0) ? ord_q.is_buy : bid_q, head_q, CW'(cnt_q + 1'b1)};
            out_d.kind          = ob_match_pkg::KIND_RESTED;
            out_d.rest_quantity = qty_q;
          end
        end
      end
      default: begin
        state_d = ob_match_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ob_match_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q     <= ord_d;
    out_q     <= out_d;
    lvl_q     <= lvl_d;
    base_q    <= base_d;
    bid_q     <= bid_d;
    head_q    <= head_d;
    cnt_q     <= cnt_d;
    qty_q     <= qty_d;
    matched_q <= matched_d;
    rej_q     <= rej_d;
  end

endmodule

`default_nettype wire

// ===== rtl/order_book_exact_price_matcher_core.sv =====
// flow: a request goes from the input buffer through the IDLE, LOOK and FINAL states,
//   a rejected one from IDLE straight to FINAL, with an EREAD step for each fill,
//   each fill walking the price level queue from its head; one request at a time in the matcher
// reset: async active low; afterwards a clearing pass writes every level state
//   entry, and no request is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none

module order_book_exact_price_matcher_core #(
  parameter int unsigned NUM_TICKERS  = 16,
  parameter int unsigned PRICE_LEVELS = 64,
  parameter int unsigned QUEUE_DEPTH  = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // is_buy, ticker_id, price_level, quantity, user_id, zero pad
  input  wire logic [ob_match_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // resting_user, incoming_user, buy_side_incoming, out_ticker, out_price,
  // fill_quantity, rest_quantity, zero pad
  output logic [ob_match_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  // kind
  output logic [1:0]                                 m_axis_tuser,
  output logic                                       m_axis_tlast
);

  logic                 busy;
  logic                 ord_valid;
  logic                 ord_pop;
  ob_match_pkg::order_t ord;
  ob_match_pkg::res_t   res;

  ob_front #(
    .NUM_TICKERS (NUM_TICKERS),
    .PRICE_LEVELS(PRICE_LEVELS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .busy_i       (busy),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .ord_valid_o  (ord_valid),
    .ord_o        (ord),
    .ord_pop_i    (ord_pop)
  );

  ob_back #(
    .NUM_TICKERS (NUM_TICKERS),
    .PRICE_LEVELS(PRICE_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (busy),
    .ord_valid_i(ord_valid),
    .ord_i      (ord),
    .ord_pop_o  (ord_pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {5'd0, res.rest_quantity, res.fill_quantity, res.out_price,
                         res.out_ticker, res.buy_side_incoming, res.incoming_user,
                         res.resting_user};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire

// ===== rtl/ob_match_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ob_match_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [ob_match_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]                          m_axis_tuser,
  input wire logic                                m_axis_tlast
);

  logic [31:0] fill_qty;
  logic [31:0] rest_qty;
  logic        is_fill;
  logic        is_rested;

  assign fill_qty  = m_axis_tdata[106:75];
  assign rest_qty  = m_axis_tdata[138:107];
  assign is_fill   = (m_axis_tuser == ob_match_pkg::KIND_FILL);
  assign is_rested = (m_axis_tuser == ob_match_pkg::KIND_RESTED);

  `OB_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `OB_ASSERT(a_fill_not_last, m_axis_tvalid && is_fill |-> !m_axis_tlast)
  `OB_ASSERT(a_status_no_fill, m_axis_tvalid && m_axis_tlast |-> (fill_qty == 32'd0))
  `OB_ASSERT(a_rest_only_rested, m_axis_tvalid && !is_rested |-> (rest_qty == 32'd0))
  `OB_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !m_axis_tvalid)

endmodule

bind order_book_exact_price_matcher_core ob_match_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
